### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_HOLDS(label, ck, rn, cond, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/rc4a_pkg.sv
// ----------------------------------------------------------------------------
// RC4A package
// Command codes and sizing constants of the RC4A stream cipher unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rc4a_pkg;

    localparam int KEY_STORE_DEPTH = 256;
    localparam int BOX_DEPTH       = 256;
    localparam logic [8:0] KEY_LENGTH_RESET = 9'd16;

    typedef enum logic [1:0] {
        KIND_LOAD_KEY = 2'd0,
        KIND_SCHEDULE = 2'd1,
        KIND_DATA     = 2'd2
    } kind_t;

endpackage

`default_nettype wire

### rtl/rc4a_stream_cipher_unit.sv
// ----------------------------------------------------------------------------
// RC4A stream cipher unit
// Two-box RC4A keystream generator with key store and key schedule sequencer.
// ----------------------------------------------------------------------------
// Input beats arrive on the s_ stream; the command kind travels in s_tuser.
// A key load beat writes one key byte and is done in its accept cycle.
// A schedule beat initializes both boxes in S_INIT and then runs the key
// schedule through S_RD_N, S_RD_W, S_WR_N and S_WR_W for each box entry,
// writing both boxes with the same values and clearing the round state.
// A data beat steps through D_RD_I, D_RD_W, D_WR_I and D_WR_W for the reads
// and swap writes on the single-port box memories plus one keystream read,
// after which D_KS loads the result beat into the m_ output register.
// Only one beat is in work at a time; s_tready is high while the unit is idle.
// If the receiver stalls, the result waits in the output register and a new
// beat is still taken; a following data beat holds in its last step until the
// output register is free.
// The key length register is written on the cfg_ channel at any time the unit
// is idle. Reset clears the control state and sets the key length to 16; the
// boxes and key store hold no defined value until scheduled or written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rc4a_stream_cipher_unit #(
    parameter int KEY_STORE_DEPTH = rc4a_pkg::KEY_STORE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // key_position [7:0], value [15:8]
    input  wire logic [1:0]  s_tuser,   // kind [1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // out_byte [7:0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [8:0]  cfg_data
);

    localparam int KW = (KEY_STORE_DEPTH > 1) ? $clog2(KEY_STORE_DEPTH) : 1;
    localparam logic [8:0] DEPTH_LEN = 9'(KEY_STORE_DEPTH);

    typedef enum logic [3:0] {
        IDLE,
        S_INIT,
        S_RD_N,
        S_RD_W,
        S_WR_N,
        S_WR_W,
        D_RD_I,
        D_RD_W,
        D_WR_I,
        D_WR_W,
        D_KS
    } state_t;

    state_t state_reg;

    logic [8:0] key_length_reg;
    logic [8:0] len_reg;
    logic [8:0] kcnt_reg;
    logic [7:0] n_reg;
    logic [7:0] sched_walk_reg;
    logic [7:0] round_index_reg;
    logic [7:0] walk_one_reg;
    logic [7:0] walk_two_reg;
    logic       second_half_reg;
    logic [7:0] bn_reg;
    logic [7:0] tw_reg;
    logic [7:0] sum_reg;
    logic [7:0] val_reg;
    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;

    logic [7:0] box_one_mem [rc4a_pkg::BOX_DEPTH];
    logic [7:0] box_two_mem [rc4a_pkg::BOX_DEPTH];
    logic [7:0] key_mem [KEY_STORE_DEPTH];

    logic [7:0]    b1_addr, b2_addr, b1_wdata, b2_wdata;
    logic          b1_we, b2_we;
    logic [7:0]    b1_rdata_reg, b2_rdata_reg;
    logic [KW-1:0] key_addr;
    logic          key_we;
    logic [7:0]    key_rdata_reg;

    logic [7:0] in_position;
    logic [7:0] in_value;
    rc4a_pkg::kind_t in_kind;
    logic       accept;
    logic [7:0] u_rdata, r_rdata;
    logic [7:0] walk_sel;
    logic [7:0] sched_walk_next;
    logic [7:0] data_walk_next;
    logic [8:0] kcnt_next;
    logic [8:0] len_next;
    logic       out_free;

    assign in_position = s_tdata[7:0];
    assign in_value    = s_tdata[15:8];
    assign in_kind     = rc4a_pkg::kind_t'(s_tuser);
    assign accept      = s_tvalid && s_tready;
    assign s_tready    = (state_reg == IDLE);
    assign cfg_ready   = 1'b1;
    assign m_tvalid    = m_tvalid_reg;
    assign m_tdata     = m_tdata_reg;
    assign out_free    = !m_tvalid_reg || m_tready;

    assign u_rdata  = second_half_reg ? b2_rdata_reg : b1_rdata_reg;
    assign r_rdata  = second_half_reg ? b1_rdata_reg : b2_rdata_reg;
    assign walk_sel = second_half_reg ? walk_two_reg : walk_one_reg;

    assign sched_walk_next = sched_walk_reg + b1_rdata_reg + key_rdata_reg;
    assign data_walk_next  = walk_sel + u_rdata;
    assign kcnt_next = (kcnt_reg + 9'd1 == len_reg) ? 9'd0 : kcnt_reg + 9'd1;
    assign len_next  = (key_length_reg == 9'd0 || key_length_reg > DEPTH_LEN) ?
                       DEPTH_LEN : key_length_reg;

    assign key_we   = accept && in_kind == rc4a_pkg::KIND_LOAD_KEY &&
                      ({1'b0, in_position} < DEPTH_LEN);
    assign key_addr = (state_reg == IDLE) ? in_position[KW-1:0] : kcnt_reg[KW-1:0];

    always_comb
    begin
        b1_addr  = n_reg;
        b1_we    = 1'b0;
        b1_wdata = n_reg;
        b2_addr  = sum_reg;
        b2_we    = 1'b0;
        b2_wdata = n_reg;
        case (state_reg)
            S_INIT:
            begin
                b1_we   = 1'b1;
                b2_addr = n_reg;
                b2_we   = 1'b1;
            end
            S_RD_N:
            begin
                b1_addr = n_reg;
            end
            S_RD_W:
            begin
                b1_addr = sched_walk_next;
            end
            S_WR_N:
            begin
                b1_we    = 1'b1;
                b1_wdata = b1_rdata_reg;
                b2_addr  = n_reg;
                b2_we    = 1'b1;
                b2_wdata = b1_rdata_reg;
            end
            S_WR_W:
            begin
                b1_addr  = sched_walk_reg;
                b1_we    = 1'b1;
                b1_wdata = bn_reg;
                b2_addr  = sched_walk_reg;
                b2_we    = 1'b1;
                b2_wdata = bn_reg;
            end
            D_RD_I, D_RD_W, D_WR_I, D_WR_W:
            begin
                // The swap addresses go to the box that this half updates, and
                // the other box is read at the keystream index.
                if (state_reg == D_RD_W)
                begin
                    b1_addr = data_walk_next;
                end
                else if (state_reg == D_WR_W)
                begin
                    b1_addr = tw_reg;
                end
                else
                begin
                    b1_addr = round_index_reg;
                end
                b1_wdata = (state_reg == D_WR_I) ? u_rdata : bn_reg;
                b1_we    = (state_reg == D_WR_I) || (state_reg == D_WR_W);
                b2_wdata = b1_wdata;
                if (second_half_reg)
                begin
                    b2_addr = b1_addr;
                    b2_we   = b1_we;
                    b1_addr = sum_reg;
                    b1_we   = 1'b0;
                end
            end
            D_KS:
            begin
                b1_addr = sum_reg;
                b2_addr = sum_reg;
            end
            default:
            begin
                b1_we = 1'b0;
                b2_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (b1_we)
        begin
            box_one_mem[b1_addr] <= b1_wdata;
        end
        b1_rdata_reg <= box_one_mem[b1_addr];
    end

    always_ff @(posedge clk)
    begin
        if (b2_we)
        begin
            box_two_mem[b2_addr] <= b2_wdata;
        end
        b2_rdata_reg <= box_two_mem[b2_addr];
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_addr] <= in_value;
        end
        key_rdata_reg <= key_mem[key_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= IDLE;
            key_length_reg  <= rc4a_pkg::KEY_LENGTH_RESET;
            round_index_reg <= 8'd0;
            walk_one_reg    <= 8'd0;
            walk_two_reg    <= 8'd0;
            second_half_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            m_tdata_reg     <= 8'd0;
            len_reg         <= DEPTH_LEN;
            kcnt_reg        <= 9'd0;
            n_reg           <= 8'd0;
            sched_walk_reg  <= 8'd0;
            bn_reg          <= 8'd0;
            tw_reg          <= 8'd0;
            sum_reg         <= 8'd0;
            val_reg         <= 8'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                key_length_reg <= cfg_data;
            end
            if (m_tvalid_reg && m_tready && state_reg != D_KS)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE:
                begin
                    if (accept)
                    begin
                        val_reg <= in_value;
                        case (in_kind)
                            rc4a_pkg::KIND_SCHEDULE:
                            begin
                                round_index_reg <= 8'd0;
                                walk_one_reg    <= 8'd0;
                                walk_two_reg    <= 8'd0;
                                second_half_reg <= 1'b0;
                                len_reg         <= len_next;
                                kcnt_reg        <= 9'd0;
                                n_reg           <= 8'd0;
                                sched_walk_reg  <= 8'd0;
                                state_reg       <= S_INIT;
                            end
                            rc4a_pkg::KIND_DATA:
                            begin
                                if (!second_half_reg)
                                begin
                                    round_index_reg <= round_index_reg + 8'd1;
                                end
                                state_reg <= D_RD_I;
                            end
                            default:
                            begin
                                state_reg <= IDLE;
                            end
                        endcase
                    end
                end
                S_INIT:
                begin
                    n_reg <= n_reg + 8'd1;
                    if (n_reg == 8'hFF)
                    begin
                        state_reg <= S_RD_N;
                    end
                end
                S_RD_N:
                begin
                    state_reg <= S_RD_W;
                end
                S_RD_W:
                begin
                    bn_reg         <= b1_rdata_reg;
                    sched_walk_reg <= sched_walk_next;
                    state_reg      <= S_WR_N;
                end
                S_WR_N:
                begin
                    state_reg <= S_WR_W;
                end
                S_WR_W:
                begin
                    n_reg    <= n_reg + 8'd1;
                    kcnt_reg <= kcnt_next;
                    if (n_reg == 8'hFF)
                    begin
                        state_reg <= IDLE;
                    end
                    else
                    begin
                        state_reg <= S_RD_N;
                    end
                end
                D_RD_I:
                begin
                    state_reg <= D_RD_W;
                end
                D_RD_W:
                begin
                    bn_reg <= u_rdata;
                    tw_reg <= data_walk_next;
                    if (second_half_reg)
                    begin
                        walk_two_reg <= data_walk_next;
                    end
                    else
                    begin
                        walk_one_reg <= data_walk_next;
                    end
                    state_reg <= D_WR_I;
                end
                D_WR_I:
                begin
                    sum_reg   <= u_rdata + bn_reg;
                    state_reg <= D_WR_W;
                end
                D_WR_W:
                begin
                    state_reg <= D_KS;
                end
                D_KS:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg    <= 1'b1;
                        m_tdata_reg     <= r_rdata ^ val_reg;
                        second_half_reg <= !second_half_reg;
                        state_reg       <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    `ASSERT_SAME(a_out_load_from_ks, clk, rst_n,
                 m_tvalid_reg && !$past(m_tvalid_reg), $past(state_reg == D_KS),
                 "result beat loaded outside the keystream step")

    `ASSERT_NEXT(a_sched_ends, clk, rst_n,
                 state_reg == S_WR_W && n_reg == 8'hFF, state_reg == IDLE,
                 "key schedule did not end after the last box entry")

    `ASSERT_HOLDS(a_key_index_range, clk, rst_n,
                  state_reg == IDLE || kcnt_reg < len_reg,
                  "key index reached the key length")

endmodule

`default_nettype wire

### sim/rc4a_keystream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4A keystream checker
// Watches the input, output and key length channels of the cipher unit. It
// keeps its own copy of the key store, both permutation boxes and the round
// state, works out the output byte of every accepted data beat, and compares
// each output beat in order against those bytes.
// ----------------------------------------------------------------------------

module rc4a_keystream_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,    // key_position [7:0], value [15:8]
    input  logic [1:0]  s_tuser,    // kind [1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,    // out_byte [7:0]
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [8:0]  cfg_data,
    output int          mismatch_count,
    output int          pending_bytes
);

    logic [7:0] key_bytes [256];
    logic [7:0] sbox_a [256];
    logic [7:0] sbox_b [256];
    logic [7:0] perm [256];
    logic [7:0] round_ctr;
    logic [7:0] walk_a;
    logic [7:0] walk_b;
    logic       odd_half;
    logic [8:0] key_len;
    logic [7:0] expected_bytes [$];

    logic [7:0] mix;
    logic [7:0] swap_tmp;
    logic [7:0] sum_idx;
    logic [7:0] keystream;
    logic [7:0] want;
    int         used_len;
    int         n;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t ns: %s", $realtime, msg);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_bytes.delete();
            key_len        = rc4a_pkg::KEY_LENGTH_RESET;
            round_ctr      = '0;
            walk_a         = '0;
            walk_b         = '0;
            odd_half       = 1'b0;
            mismatch_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                key_len = cfg_data;
            end

            if (s_tvalid && s_tready)
            begin
                case (s_tuser)
                    rc4a_pkg::KIND_LOAD_KEY:
                    begin
                        key_bytes[s_tdata[7:0]] = s_tdata[15:8];
                    end
                    rc4a_pkg::KIND_SCHEDULE:
                    begin
                        // A length of zero or beyond the store uses the whole store.
                        used_len = (key_len == 0 || key_len > rc4a_pkg::KEY_STORE_DEPTH) ?
                                   rc4a_pkg::KEY_STORE_DEPTH : int'(key_len);
                        for (n = 0; n < rc4a_pkg::BOX_DEPTH; n++)
                        begin
                            perm[n] = 8'(n);
                        end
                        mix = '0;
                        for (n = 0; n < rc4a_pkg::BOX_DEPTH; n++)
                        begin
                            mix      = mix + perm[n] + key_bytes[n % used_len];
                            swap_tmp = perm[n];
                            perm[n]  = perm[mix];
                            perm[mix] = swap_tmp;
                        end
                        sbox_a    = perm;
                        sbox_b    = perm;
                        round_ctr = '0;
                        walk_a    = '0;
                        walk_b    = '0;
                        odd_half  = 1'b0;
                    end
                    rc4a_pkg::KIND_DATA:
                    begin
                        if (!odd_half)
                        begin
                            round_ctr         = round_ctr + 8'd1;
                            walk_a            = walk_a + sbox_a[round_ctr];
                            swap_tmp          = sbox_a[round_ctr];
                            sbox_a[round_ctr] = sbox_a[walk_a];
                            sbox_a[walk_a]    = swap_tmp;
                            sum_idx           = sbox_a[round_ctr] + sbox_a[walk_a];
                            keystream         = sbox_b[sum_idx];
                        end
                        else
                        begin
                            walk_b            = walk_b + sbox_b[round_ctr];
                            swap_tmp          = sbox_b[round_ctr];
                            sbox_b[round_ctr] = sbox_b[walk_b];
                            sbox_b[walk_b]    = swap_tmp;
                            sum_idx           = sbox_b[round_ctr] + sbox_b[walk_b];
                            keystream         = sbox_a[sum_idx];
                        end
                        odd_half = ~odd_half;
                        expected_bytes.push_back(keystream ^ s_tdata[15:8]);
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    report_mismatch($sformatf("output beat %02h with no byte expected",
                                              m_tdata));
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want)
                    begin
                        report_mismatch($sformatf("out_byte expected %02h, got %02h",
                                                  want, m_tdata));
                    end
                end
            end
        end
        pending_bytes = expected_bytes.size();
    end

endmodule

### sim/rc4a_stream_cipher_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4A stream cipher unit testbench
// Fills the key store, runs a short directed sequence of key loads, schedules,
// data bytes and unused commands, then keyed sessions with random content
// under a series of key lengths, with random gaps and output stalls. The
// checker beside the unit predicts and compares every output byte.
// ----------------------------------------------------------------------------

module rc4a_stream_cipher_unit_tb;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 1600;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [8:0]  cfg_data;

    int          mismatch_count;
    int          pending_bytes;
    bit          idling;
    int          beats_sent;
    logic [8:0]  key_len_now;

    rc4a_stream_cipher_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    rc4a_keystream_checker keystream_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_bytes  (pending_bytes)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    initial
    begin
        #12_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (idling && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(negedge clk);
            end
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_beat(input logic [1:0] kind, input logic [7:0] key_pos,
                             input logic [7:0] val);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10) - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {val, key_pos};
        do
            @(posedge clk);
        while (!s_tready);
        if (kind != KIND_UNUSED)
        begin
            beats_sent++;
        end
    endtask

    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pending_bytes == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_key_length(input logic [8:0] len);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        key_len_now = len;
    endtask

    task automatic run_session(input int data_count);
        int used_len;
        int n_keys;
        int k;
        int pick;
        used_len = (key_len_now == 0 || key_len_now > rc4a_pkg::KEY_STORE_DEPTH) ?
                   rc4a_pkg::KEY_STORE_DEPTH : int'(key_len_now);
        n_keys = $urandom_range(0, 6);
        for (k = 0; k < n_keys; k++)
        begin
            if ($urandom_range(0, 3) != 0)
                push_beat(rc4a_pkg::KIND_LOAD_KEY, 8'($urandom_range(0, used_len - 1)),
                          pick_byte());
            else
                push_beat(rc4a_pkg::KIND_LOAD_KEY, 8'($urandom_range(0, 255)),
                          pick_byte());
        end
        if ($urandom_range(0, 4) != 0)
        begin
            push_beat(rc4a_pkg::KIND_SCHEDULE, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
        end
        for (k = 0; k < data_count; k++)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                push_beat(KIND_UNUSED, 8'($urandom_range(0, 255)), pick_byte());
            else if (pick == 1)
                push_beat(rc4a_pkg::KIND_LOAD_KEY, 8'($urandom_range(0, 255)),
                          pick_byte());
            push_beat(rc4a_pkg::KIND_DATA, 8'($urandom_range(0, 255)), pick_byte());
        end
    endtask

    initial
    begin
        logic [8:0] phase_len [8];
        int         p;
        int         phase_start;

        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = rc4a_pkg::KIND_LOAD_KEY;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        idling      = 1'b1;
        beats_sent  = 0;
        key_len_now = rc4a_pkg::KEY_LENGTH_RESET;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Every key store entry is written before the first schedule reads it.
        for (p = 0; p < rc4a_pkg::KEY_STORE_DEPTH; p++)
        begin
            push_beat(rc4a_pkg::KIND_LOAD_KEY, 8'(p), pick_byte());
        end

        push_beat(rc4a_pkg::KIND_SCHEDULE, 8'h00, 8'h00);
        push_beat(rc4a_pkg::KIND_DATA, 8'h00, 8'h00);
        push_beat(rc4a_pkg::KIND_DATA, 8'hFF, 8'hFF);
        push_beat(rc4a_pkg::KIND_DATA, 8'h00, 8'hA5);
        push_beat(KIND_UNUSED, 8'hFF, 8'hFF);
        push_beat(rc4a_pkg::KIND_LOAD_KEY, 8'hFF, 8'h00);
        push_beat(rc4a_pkg::KIND_LOAD_KEY, 8'h00, 8'hFF);
        push_beat(rc4a_pkg::KIND_LOAD_KEY, 8'h0F, 8'h00);
        push_beat(rc4a_pkg::KIND_SCHEDULE, 8'hFF, 8'hFF);
        push_beat(rc4a_pkg::KIND_DATA, 8'h00, 8'h00);
        push_beat(rc4a_pkg::KIND_DATA, 8'h00, 8'hFF);
        push_beat(rc4a_pkg::KIND_DATA, 8'h00, 8'h5A);
        push_beat(rc4a_pkg::KIND_DATA, 8'h00, 8'h3C);
        push_beat(KIND_UNUSED, 8'h00, 8'h00);
        push_beat(rc4a_pkg::KIND_DATA, 8'h00, 8'h81);
        push_beat(rc4a_pkg::KIND_SCHEDULE, 8'h00, 8'h00);
        push_beat(rc4a_pkg::KIND_SCHEDULE, 8'h00, 8'h00);
        push_beat(rc4a_pkg::KIND_DATA, 8'h00, 8'h7E);

        phase_len[0] = 9'd1;
        phase_len[1] = 9'd256;
        phase_len[2] = 9'd0;
        phase_len[3] = 9'd511;
        phase_len[4] = 9'd257;
        phase_len[5] = 9'd2;
        phase_len[6] = 9'd255;
        phase_len[7] = 9'($urandom_range(3, 254));

        for (p = 0; p < 8; p++)
        begin
            settle();
            write_key_length(phase_len[p]);
            phase_start = beats_sent;
            if (p == 1)
            begin
                // Long enough for the round index to wrap.
                idling = 1'b1;
                run_session(520);
            end
            while (beats_sent - phase_start < 10)
            begin
                idling = (p != 7) && ($urandom_range(0, 3) != 0);
                run_session($urandom_range(1, 16));
            end
        end

        settle();
        if (mismatch_count == 0 && pending_bytes == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
